>>> rtl/framed_packet_deframer_resync_core_macros.svh
// Assertion macros for the framed packet deframer.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef FRAMED_PACKET_DEFRAMER_RESYNC_CORE_MACROS_SVH
`define FRAMED_PACKET_DEFRAMER_RESYNC_CORE_MACROS_SVH

// same-cycle implication
`define FPDR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// next-cycle implication
`define FPDR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

>>> rtl/fpdr_pkg.sv
// Package for the framed packet deframer: beat types, codes, CRC step.
// No dependencies.
`timescale 1ns / 1ps
package fpdr_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} fpdr_in_t;

	typedef struct packed {
		logic        frame_valid;
		logic [7:0]  version;
		logic [7:0]  frame_type;
		logic [5:0]  payload_length;
		logic [5:0]  byte_index;
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        frame_end;
		logic        run_end;
		logic [31:0] corrupt_count;
		logic [31:0] discarded_count;
	} fpdr_out_t;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0]  MAGIC_FIRST_RST = 8'hA5;
	localparam logic [7:0]  MAGIC_SECOND_RST = 8'h5A;
	localparam logic [7:0]  REG_MAGIC_FIRST = 8'd0;
	localparam logic [7:0]  REG_MAGIC_SECOND = 8'd1;
	localparam int          HDR_LEN = 6;
	localparam int          CRC_LEN = 2;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] d);
		logic [15:0] c;
		c = crc_in ^ {d, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> rtl/framed_packet_deframer_resync_core.sv
// Deframer top level: magic pair, version, type, LE length, payload, LE CRC-16/CCITT-FALSE.
// Depends on fpdr_pkg, fpdr_chain, framed_packet_deframer_resync_core_macros.svh.
`timescale 1ns / 1ps
`include "framed_packet_deframer_resync_core_macros.svh"

// Received bytes sit in a circular chain of byte cells; all parsing reads the head of the chain.
// Each input beat is parsed before the next is taken: dropped bytes are rotated out one at a time,
// each CRC check rotates the chain through a full turn, and each payload beat waits for the
// output register to drain.
// One status beat closes every input beat.
module framed_packet_deframer_resync_core
	import fpdr_pkg::*;
#(
	parameter int BUFFER_BYTES = 64,
	parameter int MAX_PAYLOAD = 56
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  fpdr_in_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output fpdr_out_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int IW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + MAX_PAYLOAD + 10);
	localparam int PW = $clog2(MAX_PAYLOAD + 2);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_CHECK   = 8'b0000_0010,
		ST_CRC     = 8'b0000_0100,
		ST_VERIFY  = 8'b0000_1000,
		ST_DROPHDR = 8'b0001_0000,
		ST_EMIT    = 8'b0010_0000,
		ST_DROPCRC = 8'b0100_0000,
		ST_STATUS  = 8'b1000_0000
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  fill_q;
	logic [31:0]    corrupt_q;
	logic [31:0]    discard_q;
	logic [7:0]     mf_q;
	logic [7:0]     ms_q;
	logic [15:0]    crc_q;
	logic [15:0]    exp_q;
	logic [CW-1:0]  j_q;
	logic [PW-1:0]  plen_q;
	logic [CW-1:0]  total_q;
	logic [7:0]     ver_q;
	logic [7:0]     typ_q;
	logic [2:0]     cnt_q;
	logic [PW-1:0]  idx_q;
	fpdr_out_t      out_q;
	logic           out_valid_q;

	logic [5:0][7:0] head;
	logic            rot;
	logic            wr_en;
	logic [IW-1:0]   wr_idx;
	logic            in_acc;
	logic            full;
	logic            is_head;
	logic [15:0]     plen16;
	logic            too_long;
	logic [CW-1:0]   total_w;
	logic            chk_drop;
	logic            crc_ok;
	logic            emit_last;

	assign in_acc = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = out_valid_q;
	assign result = out_q;

	assign full = (fill_q >= CW'(BUFFER_BYTES));
	assign is_head = (fill_q >= CW'(2)) && (head[0] == mf_q) && (head[1] == ms_q);
	assign plen16 = {head[5], head[4]};
	assign too_long = (plen16 > 16'(MAX_PAYLOAD));
	assign total_w = CW'(plen16[PW-1:0]) + CW'(HDR_LEN + CRC_LEN);
	assign crc_ok = (crc_q == exp_q);
	assign emit_last = (plen_q == '0) || (idx_q + PW'(1) == plen_q);

	always_comb begin
		if (is_head) begin
			chk_drop = (fill_q >= CW'(HDR_LEN)) && too_long;
		end else begin
			chk_drop = !((fill_q == '0) || ((fill_q == CW'(1)) && (head[0] == mf_q)));
		end
	end

	assign wr_en = in_acc && !item.mode;
	assign wr_idx = full ? IW'(BUFFER_BYTES - 1) : fill_q[IW-1:0];

	always_comb begin
		unique case (state_q)
			ST_IDLE:    rot = wr_en && full;
			ST_CHECK:   rot = chk_drop;
			ST_CRC:     rot = 1'b1;
			ST_VERIFY:  rot = !crc_ok;
			ST_DROPHDR: rot = 1'b1;
			ST_EMIT:    rot = !out_valid_q && (plen_q != '0);
			ST_DROPCRC: rot = 1'b1;
			ST_STATUS:  rot = 1'b0;
			default:    rot = 1'b0;
		endcase
	end

	fpdr_chain #(.DEPTH(BUFFER_BYTES)) u_chain (
		.clk    (clk),
		.rot    (rot),
		.wr_en  (wr_en),
		.wr_idx (wr_idx),
		.wr_data(item.data_byte),
		.head   (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mf_q <= MAGIC_FIRST_RST;
			ms_q <= MAGIC_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAGIC_FIRST:  mf_q <= cfg_data;
				REG_MAGIC_SECOND: ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CHECK: begin
				j_q <= '0;
				crc_q <= CRC_INIT;
				plen_q <= plen16[PW-1:0];
				total_q <= total_w;
			end
			ST_CRC: begin
				j_q <= j_q + CW'(1);
				if ((j_q >= CW'(2)) && (j_q < total_q - CW'(2))) begin
					crc_q <= crc16_byte(crc_q, head[0]);
				end
				if (j_q == total_q - CW'(2)) begin
					exp_q[7:0] <= head[0];
				end
				if (j_q == total_q - CW'(1)) begin
					exp_q[15:8] <= head[0];
				end
			end
			ST_VERIFY: begin
				ver_q <= head[2];
				typ_q <= head[3];
				cnt_q <= '0;
				idx_q <= '0;
			end
			ST_DROPHDR, ST_DROPCRC: cnt_q <= cnt_q + 3'd1;
			ST_EMIT: begin
				if (!out_valid_q) begin
					idx_q <= idx_q + PW'(1);
					cnt_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			corrupt_q <= '0;
			discard_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (item.mode) begin
							fill_q <= '0;
							state_q <= ST_STATUS;
						end else begin
							if (full) begin
								discard_q <= discard_q + 32'd1;
							end else begin
								fill_q <= fill_q + CW'(1);
							end
							if ((full ? fill_q : fill_q + CW'(1)) >= CW'(HDR_LEN)) begin
								state_q <= ST_CHECK;
							end else begin
								state_q <= ST_STATUS;
							end
						end
					end
				end
				ST_CHECK: begin
					if (chk_drop) begin
						fill_q <= fill_q - CW'(1);
						discard_q <= discard_q + 32'd1;
					end else if (!is_head || (fill_q < CW'(HDR_LEN)) || (fill_q < total_w)) begin
						state_q <= ST_STATUS;
					end else begin
						state_q <= ST_CRC;
					end
				end
				ST_CRC: begin
					if (j_q == CW'(BUFFER_BYTES - 1)) begin
						state_q <= ST_VERIFY;
					end
				end
				ST_VERIFY: begin
					if (!crc_ok) begin
						corrupt_q <= corrupt_q + 32'd1;
						discard_q <= discard_q + 32'd1;
						fill_q <= fill_q - CW'(1);
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_DROPHDR;
					end
				end
				ST_DROPHDR: begin
					fill_q <= fill_q - CW'(1);
					if (cnt_q == 3'(HDR_LEN - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_q.frame_valid <= 1'b1;
						out_q.version <= ver_q;
						out_q.frame_type <= typ_q;
						out_q.payload_length <= 6'(plen_q);
						out_q.byte_index <= 6'(idx_q);
						out_q.payload_byte <= (plen_q == '0) ? 8'd0 : head[0];
						out_q.byte_valid <= (plen_q != '0);
						out_q.frame_end <= emit_last;
						out_q.run_end <= 1'b0;
						out_q.corrupt_count <= corrupt_q;
						out_q.discarded_count <= discard_q;
						if (plen_q != '0) begin
							fill_q <= fill_q - CW'(1);
						end
						if (emit_last) begin
							state_q <= ST_DROPCRC;
						end
					end
				end
				ST_DROPCRC: begin
					fill_q <= fill_q - CW'(1);
					if (cnt_q == 3'(CRC_LEN - 1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_STATUS: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_q <= '{1'b0, 8'd0, 8'd0, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0, 1'b1,
							corrupt_q, discard_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FPDR_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CW'(BUFFER_BYTES))
	`FPDR_ASSERT_NXT(a_drop_clears, in_acc && item.mode, fill_q == '0)
	`FPDR_ASSERT_IMP(a_corrupt_step, !$stable(corrupt_q), corrupt_q == $past(corrupt_q) + 32'd1)
endmodule

>>> rtl/fpdr_cell.sv
// One byte cell of the deframer buffer chain.
// Depends on nothing.
`timescale 1ns / 1ps
module fpdr_cell (
	input  logic       clk,
	input  logic       rot,
	input  logic       wr,
	input  logic [7:0] wr_data,
	input  logic [7:0] nbr,
	output logic [7:0] q
);
	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			byte_q <= wr_data;
		end else if (rot) begin
			byte_q <= nbr;
		end
	end

	assign q = byte_q;
endmodule

>>> rtl/fpdr_chain.sv
// Circular chain of byte cells; rotates toward cell 0, exposes the six head bytes.
// Depends on fpdr_cell.
`timescale 1ns / 1ps
module fpdr_chain #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     rot,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	input  logic [7:0]               wr_data,
	output logic [5:0][7:0]          head
);
	logic [DEPTH-1:0][7:0] q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		fpdr_cell u_cell (
			.clk    (clk),
			.rot    (rot),
			.wr     (wr_en && (wr_idx == ($clog2(DEPTH))'(i))),
			.wr_data(wr_data),
			.nbr    (q[(i + 1) % DEPTH]),
			.q      (q[i])
		);
	end

	for (genvar h = 0; h < 6; h++) begin : g_head
		assign head[h] = q[h];
	end
endmodule
